@@ rtl/ppc_pkg.sv @@
// shared constants, types and helpers of the polynomial position correction
package ppc_pkg;

  localparam int POSITION_BITS = 12;
  localparam int NUM_COEFS     = 4;
  localparam int COEF_REGS     = 4;

  localparam int X_W       = POSITION_BITS;
  localparam int SQ_W      = 2 * X_W;
  localparam int CU_W      = 3 * X_W;
  localparam int COEF_W    = 48;
  localparam int HALF_W    = COEF_W / 2;
  localparam int FRAC_BITS = 32;
  localparam int OUT_FRAC  = 8;
  localparam int SHIFT     = FRAC_BITS - OUT_FRAC;
  localparam int RES_W     = 13;
  localparam int OUT_W     = 24;

  // signed partial product of a coefficient half and a power of x
  localparam int PROD_W = HALF_W + CU_W + 2;
  // exact accumulator, headroom for the sum of all terms
  localparam int ACC_W  = COEF_W + CU_W + 4;
  localparam int RND_W  = ACC_W - SHIFT;

  localparam int IN_DATA_W  = ((X_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [RES_W-1:0] RESOLUTION_RESET = RES_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_CONSTANT = 3'd0,
    REG_COEF_LINEAR   = 3'd1,
    REG_COEF_SQUARE   = 3'd2,
    REG_COEF_CUBE     = 3'd3,
    REG_RESOLUTION    = 3'd4
  } reg_idx_t;

  function automatic logic signed [ACC_W-1:0] sext_prod(input logic signed [PROD_W-1:0] v);
    return {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] sext_coef(input logic [COEF_W-1:0] c);
    return {{(ACC_W-COEF_W){c[COEF_W-1]}}, c};
  endfunction

endpackage

@@ rtl/polynomial_position_correction_top.sv @@
// top level: cubic polynomial correction of raw detector positions
// an accepted item passes through stages 1 to 9 and then the output register
// throughput: one item per cycle unless the output stalls; ten stages, no shared unit
// each stage holds its item while the next one is full and held, so stalls lose nothing
// reset (rst, synchronous) empties the pipeline, clears the coefficients and
// sets resolution to 512
module polynomial_position_correction_top
  import ppc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // [11:0] raw_position, rest zero
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // [23:0] corrected_position
  output logic [1:0]             m_tuser,   // [0] in_range, [1] saturated
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  // configuration registers
  logic [COEF_W-1:0] coef_constant;
  logic [COEF_W-1:0] coef_linear;
  logic [COEF_W-1:0] coef_square;
  logic [COEF_W-1:0] coef_cube;
  logic [RES_W-1:0]  resolution;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_constant <= '0;
      coef_linear   <= '0;
      coef_square   <= '0;
      coef_cube     <= '0;
      resolution    <= RESOLUTION_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COEF_CONSTANT: coef_constant <= pwdata[COEF_W-1:0];
        REG_COEF_LINEAR:   coef_linear   <= pwdata[COEF_W-1:0];
        REG_COEF_SQUARE:   coef_square   <= pwdata[COEF_W-1:0];
        REG_COEF_CUBE:     coef_cube     <= pwdata[COEF_W-1:0];
        REG_RESOLUTION:    resolution    <= pwdata[RES_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COEF_CONSTANT: prdata = {{(DATA_W-COEF_W){1'b0}}, coef_constant};
      REG_COEF_LINEAR:   prdata = {{(DATA_W-COEF_W){1'b0}}, coef_linear};
      REG_COEF_SQUARE:   prdata = {{(DATA_W-COEF_W){1'b0}}, coef_square};
      REG_COEF_CUBE:     prdata = {{(DATA_W-COEF_W){1'b0}}, coef_cube};
      REG_RESOLUTION:    prdata = {{(DATA_W-RES_W){1'b0}}, resolution};
      default:           prdata = '0;
    endcase
  end

  // coefficients actually used; terms past the configured count are zero
  logic [COEF_W-1:0] cf [0:COEF_REGS-1];

  always_comb begin
    cf[0] = (NUM_COEFS > 0) ? coef_constant : '0;
    cf[1] = (NUM_COEFS > 1) ? coef_linear   : '0;
    cf[2] = (NUM_COEFS > 2) ? coef_square   : '0;
    cf[3] = (NUM_COEFS > 3) ? coef_cube     : '0;
  end

  // pipeline valid bits and per-stage advance
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, out_vld;
  logic r1, r2, r3, r4, r5, r6, r7, r8, r9, rout;

  // a stage takes new data when it is empty or its content moves on
  assign rout = !out_vld || m_tready;
  assign r9   = !v9 || rout;
  assign r8   = !v8 || r9;
  assign r7   = !v7 || r8;
  assign r6   = !v6 || r7;
  assign r5   = !v5 || r6;
  assign r4   = !v4 || r5;
  assign r3   = !v3 || r4;
  assign r2   = !v2 || r3;
  assign r1   = !v1 || r2;

  assign s_tready = r1;
  assign m_tvalid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      v5      <= 1'b0;
      v6      <= 1'b0;
      v7      <= 1'b0;
      v8      <= 1'b0;
      v9      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (r1)   v1      <= s_tvalid;
      if (r2)   v2      <= v1;
      if (r3)   v3      <= v2;
      if (r4)   v4      <= v3;
      if (r5)   v5      <= v4;
      if (r6)   v6      <= v5;
      if (r7)   v7      <= v6;
      if (r8)   v8      <= v7;
      if (r9)   v9      <= v8;
      if (rout) out_vld <= v9;
    end
  end

  // datapath registers
  logic [X_W-1:0]  x1, x2, x3, x4, x5, x6, x7;
  logic [SQ_W-1:0] sq2, sq3;
  logic [CU_W-1:0] cu3;

  logic signed [PROD_W-1:0] ph4 [1:COEF_REGS-1];  // upper coefficient half times power
  logic signed [PROD_W-1:0] pl4 [1:COEF_REGS-1];  // lower coefficient half times power
  logic signed [ACC_W-1:0]  t5  [1:COEF_REGS-1];
  logic signed [ACC_W-1:0]  sa6, sb6, sum7, val8;
  logic [RND_W-1:0]         rnd9;
  logic                     inr9;

  logic [OUT_W-1:0] corrected_position;
  logic             in_range;
  logic             saturated;

  // powers of x feeding the order-1..3 products
  logic [CU_W-1:0]         pw [1:COEF_REGS-1];
  logic signed [ACC_W-1:0] val_half;
  logic signed [ACC_W-1:0] lim;
  logic                    fits;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (SHIFT - 1));

  always_comb begin
    pw[1] = {{(CU_W-X_W){1'b0}}, x3};
    pw[2] = {{(CU_W-SQ_W){1'b0}}, sq3};
    pw[3] = cu3;
  end

  // round to nearest, ties up
  assign val_half = val8 + HALF_LSB;
  // upper bound of the range in the accumulator's fixed point
  assign lim = $signed({{(ACC_W-RES_W-FRAC_BITS){1'b0}}, resolution, {FRAC_BITS{1'b0}}});
  // rounded value fits when the output sign bit and all bits above it agree
  assign fits = (&rnd9[RND_W-1:OUT_W-1]) || !(|rnd9[RND_W-1:OUT_W-1]);

  always_ff @(posedge clk) begin
    // stage 1: capture position
    if (r1) x1 <= s_tdata[X_W-1:0];
    // stage 2: square
    if (r2) begin
      x2  <= x1;
      sq2 <= x1 * x1;
    end
    // stage 3: cube
    if (r3) begin
      x3  <= x2;
      sq3 <= sq2;
      cu3 <= sq2 * {{(SQ_W-X_W){1'b0}}, x2};
    end
    // stage 4: split each coefficient product into two narrower multiplies
    if (r4) begin
      x4 <= x3;
      for (int k = 1; k < COEF_REGS; k++) begin
        ph4[k] <= $signed(cf[k][COEF_W-1:HALF_W]) * $signed({1'b0, pw[k]});
        pl4[k] <= $signed({1'b0, cf[k][HALF_W-1:0]}) * $signed({1'b0, pw[k]});
      end
    end
    // stage 5: recombine the halves of each term
    if (r5) begin
      x5 <= x4;
      for (int k = 1; k < COEF_REGS; k++) begin
        t5[k] <= (sext_prod(ph4[k]) <<< HALF_W) + sext_prod(pl4[k]);
      end
    end
    // stage 6: pairwise sums
    if (r6) begin
      x6  <= x5;
      sa6 <= t5[1] + t5[2];
      sb6 <= t5[3] + sext_coef(cf[0]);
    end
    // stage 7: polynomial value
    if (r7) begin
      x7   <= x6;
      sum7 <= sa6 + sb6;
    end
    // stage 8: exact corrected position
    if (r8) begin
      val8 <= $signed({{(ACC_W-X_W-FRAC_BITS){1'b0}}, x7, {FRAC_BITS{1'b0}}}) - sum7;
    end
    // stage 9: rounding and range check on the exact value
    if (r9) begin
      rnd9 <= val_half[ACC_W-1:SHIFT];
      inr9 <= !val8[ACC_W-1] && (val8 <= lim);
    end
    // output register: saturate
    if (rout) begin
      in_range  <= inr9;
      saturated <= !fits;
      if (fits) begin
        corrected_position <= rnd9[OUT_W-1:0];
      end else if (rnd9[RND_W-1]) begin
        corrected_position <= {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        corrected_position <= {1'b0, {(OUT_W-1){1'b1}}};
      end
    end
  end

  assign m_tdata = {{(OUT_DATA_W-OUT_W){1'b0}}, corrected_position};
  assign m_tuser = {saturated, in_range};

`ifndef NO_ASSERTIONS
  // a clipped result sits at one of the two range ends
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |->
      (m_tdata[OUT_W-1:0] == {1'b1, {(OUT_W-1){1'b0}}} ||
       m_tdata[OUT_W-1:0] == {1'b0, {(OUT_W-1){1'b1}}}))
    else $error("saturated result not at a range limit");

  // an in-range result is never negative and never clipped
  a_in_range_sane: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (!m_tdata[OUT_W-1] && !m_tuser[1]))
    else $error("in-range result negative or clipped");

  // with the output side taking items the pipeline never blocks its input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output ready");

  // after reset the output is empty
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
